>>> design/idll_pkg.sv
// package for the indexed doubly linked list unit
// types, operation and status codes; no dependencies
`default_nettype none
package idll_pkg;
    localparam int SLOTS_DEF    = 256;
    localparam int KEY_BITS_DEF = 32;

    typedef enum logic [2:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_INS_AFTER  = 3'd2,
        FN_INS_BEFORE = 3'd3,
        FN_DELETE     = 3'd4,
        FN_SEARCH     = 3'd5,
        FN_NOP6       = 3'd6,
        FN_NOP7       = 3'd7
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_BADPOS   = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  position;
        logic [31:0] key_value;
    } t_in_word;

    typedef struct packed {
        logic [7:0] slot_index;
        logic [1:0] status;
    } t_out_word;
endpackage
`default_nettype wire

>>> design/indexed_doubly_linked_list_unit.sv
// top level of the indexed doubly linked list unit
// depends on idll_pkg; holds the link, key and mark memories and the sequencer
//
// Usage: one input word (func, position, key_value) on i_in_valid/o_in_ready
// gives one output word (slot_index, status) on o_out_valid/i_out_ready.
// One operation runs at a time. Links, keys and occupied marks sit in
// synchronous memories with a registered read port; a sequencer reads,
// modifies and writes them back.
// A search reads one key and mark per slot, scanning from slot 1 up to the
// last slot. Unused func codes answer with slot index 0 and status OK.
// The result sits in an output register; the next word is taken once the
// current result has been taken.
// After reset a clearing pass over all slots writes the free chain and
// clears the marks; no input word is accepted meanwhile.
// A stalled receiver just holds the result register and the sequencer.
`default_nettype none
module indexed_doubly_linked_list_unit #(
    parameter int SLOTS    = idll_pkg::SLOTS_DEF,
    parameter int KEY_BITS = idll_pkg::KEY_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire idll_pkg::t_in_word  i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output idll_pkg::t_out_word      o_out_word
);
    import idll_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int PW = ((AW + 1) > 8) ? (AW + 1) : 8;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD_FREE, S_GOT_FREE, S_RD_POS, S_GOT_POS,
        S_LINK, S_RD_SRCH, S_CMP_SRCH, S_DONE
    } t_state;

    // memories
    logic [AW-1:0]       mem_next [SLOTS];
    logic [AW-1:0]       mem_prev [SLOTS];
    logic                mem_occ  [SLOTS];
    logic [KEY_BITS-1:0] mem_key  [SLOTS];

    logic          nx_we, pv_we, oc_we, ky_we, nx_we2, pv_we2;
    logic [AW-1:0] nx_wa, pv_wa, oc_wa, ky_wa, nx_wa2, pv_wa2, ra;
    logic [AW-1:0] nx_wd, pv_wd, nx_wd2, pv_wd2;
    logic          oc_wd;
    logic [AW-1:0] r_nx_q, r_pv_q;
    logic          r_oc_q;
    logic [KEY_BITS-1:0] r_ky_q;

    t_state        r_state;
    t_in_word      r_in;
    logic [AW-1:0] r_head, r_tail, r_free, r_cnt, r_new, r_pos, r_pn, r_pp;
    logic [AW:0]   r_scan;
    t_out_word     r_out;
    logic          r_out_valid;
    logic          pos_ok_range;

    function automatic logic [KEY_BITS-1:0] i_key_masked(input logic [31:0] k);
        logic [63:0] w;
        w = {32'd0, k};
        return w[KEY_BITS-1:0];
    endfunction

    // read port shared by all memories, write ports per memory
    always_ff @(posedge i_clk) begin
        r_nx_q <= mem_next[ra];
        r_pv_q <= mem_prev[ra];
        r_oc_q <= mem_occ[ra];
        r_ky_q <= mem_key[ra];
        if (nx_we)  mem_next[nx_wa] <= nx_wd;
        if (pv_we)  mem_prev[pv_wa] <= pv_wd;
        if (oc_we)  mem_occ[oc_wa]  <= oc_wd;
        if (ky_we)  mem_key[ky_wa]  <= i_key_masked(r_in.key_value);
        if (nx_we2) mem_next[nx_wa2] <= nx_wd2;
        if (pv_we2) mem_prev[pv_wa2] <= pv_wd2;
    end

    assign pos_ok_range = (r_in.position != 8'd0) &&
                          ({{(PW-8){1'b0}}, r_in.position} < PW'(SLOTS));
    wire [AW-1:0] pos_a = AW'({{(PW-8){1'b0}}, r_in.position});
    wire          is_ins = (r_in.func == FN_INS_AFTER) || (r_in.func == FN_INS_BEFORE);

    // read address select
    always_comb begin
        case (r_state)
            S_RD_FREE: ra = r_free;
            S_RD_POS:  ra = pos_a;
            S_RD_SRCH: ra = r_scan[AW-1:0];
            default:   ra = '0;
        endcase
    end

    // writes for the clearing pass and the link step; the second ports serve the link step only
    always_comb begin
        nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
        pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
        nx_we2 = 1'b0; nx_wa2 = '0; nx_wd2 = '0;
        pv_we2 = 1'b0; pv_wa2 = '0; pv_wd2 = '0;
        oc_we = 1'b0; oc_wa = '0; oc_wd = 1'b0;
        ky_we = 1'b0; ky_wa = '0;
        case (r_state)
            S_CLEAR: begin
                nx_we = 1'b1; nx_wa = r_scan[AW-1:0];
                nx_wd = (r_scan != '0 && r_scan < (AW+1)'(SLOTS-1)) ?
                        AW'(r_scan + 1'b1) : '0;
                pv_we = 1'b1; pv_wa = r_scan[AW-1:0];
                oc_we = 1'b1; oc_wa = r_scan[AW-1:0];
            end
            S_LINK: begin
                if (r_in.func == FN_DELETE) begin
                    if (r_pp != '0) begin
                        nx_we2 = 1'b1; nx_wa2 = r_pp; nx_wd2 = r_pn;
                    end
                    if (r_pn != '0) begin
                        pv_we2 = 1'b1; pv_wa2 = r_pn; pv_wd2 = r_pp;
                    end
                    nx_we = 1'b1; nx_wa = r_pos; nx_wd = r_free;
                    pv_we = 1'b1; pv_wa = r_pos; pv_wd = '0;
                    oc_we = 1'b1; oc_wa = r_pos; oc_wd = 1'b0;
                end else begin
                    oc_we = 1'b1; oc_wa = r_new; oc_wd = 1'b1;
                    ky_we = 1'b1; ky_wa = r_new;
                    nx_we = 1'b1; nx_wa = r_new;
                    pv_we = 1'b1; pv_wa = r_new;
                    case (r_in.func)
                        FN_PUSH_FRONT: begin
                            nx_wd = r_head; pv_wd = '0;
                            if (r_head != '0) begin
                                pv_we2 = 1'b1; pv_wa2 = r_head; pv_wd2 = r_new;
                            end
                        end
                        FN_PUSH_BACK: begin
                            nx_wd = '0; pv_wd = r_tail;
                            if (r_tail != '0) begin
                                nx_we2 = 1'b1; nx_wa2 = r_tail; nx_wd2 = r_new;
                            end
                        end
                        FN_INS_AFTER: begin
                            nx_wd = r_pn; pv_wd = r_pos;
                            nx_we2 = 1'b1; nx_wa2 = r_pos; nx_wd2 = r_new;
                            if (r_pn != '0) begin
                                pv_we2 = 1'b1; pv_wa2 = r_pn; pv_wd2 = r_new;
                            end
                        end
                        default: begin
                            nx_wd = r_pos; pv_wd = r_pp;
                            pv_we2 = 1'b1; pv_wa2 = r_pos; pv_wd2 = r_new;
                            if (r_pp != '0) begin
                                nx_we2 = 1'b1; nx_wa2 = r_pp; nx_wd2 = r_new;
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_scan <= '0;
            r_head <= '0; r_tail <= '0; r_free <= AW'(1); r_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_scan <= r_scan + 1'b1;
                    if (r_scan == (AW+1)'(SLOTS-1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_in <= i_in_word;
                        r_pos <= AW'({{(PW-8){1'b0}}, i_in_word.position});
                        case (i_in_word.func)
                            FN_PUSH_FRONT, FN_PUSH_BACK: r_state <= S_RD_FREE;
                            FN_INS_AFTER, FN_INS_BEFORE, FN_DELETE: r_state <= S_RD_POS;
                            FN_SEARCH: begin
                                r_scan <= (AW+1)'(1);
                                r_state <= S_RD_SRCH;
                            end
                            default: begin
                                r_out <= '{slot_index: 8'd0, status: ST_OK};
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RD_POS: r_state <= S_GOT_POS;
                S_GOT_POS: begin
                    r_pn <= r_nx_q; r_pp <= r_pv_q;
                    if (!pos_ok_range || !r_oc_q) begin
                        r_out <= '{slot_index: 8'd0, status: ST_BADPOS};
                        r_state <= S_DONE;
                    end else if (r_in.func == FN_DELETE) begin
                        r_state <= S_LINK;
                    end else begin
                        r_state <= S_RD_FREE;
                    end
                end
                S_RD_FREE: begin
                    if (r_free == '0) begin
                        r_out <= '{slot_index: 8'd0, status: ST_FULL};
                        r_state <= S_DONE;
                    end else begin
                        r_new <= r_free;
                        r_state <= S_GOT_FREE;
                    end
                end
                S_GOT_FREE: begin
                    r_free <= r_nx_q;
                    r_state <= S_LINK;
                end
                S_LINK: begin
                    if (r_in.func == FN_DELETE) begin
                        if (r_pp == '0) r_head <= r_pn;
                        if (r_pn == '0) r_tail <= r_pp;
                        r_free <= r_pos;
                        r_cnt <= r_cnt - 1'b1;
                        r_out <= '{slot_index: 8'd0, status: ST_OK};
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                        case (r_in.func)
                            FN_PUSH_FRONT: begin
                                r_head <= r_new;
                                if (r_head == '0) r_tail <= r_new;
                            end
                            FN_PUSH_BACK: begin
                                r_tail <= r_new;
                                if (r_tail == '0) r_head <= r_new;
                            end
                            FN_INS_AFTER: if (r_pn == '0) r_tail <= r_new;
                            default: if (r_pp == '0) r_head <= r_new;
                        endcase
                        r_out <= '{slot_index: 8'(r_new), status: ST_OK};
                    end
                    r_state <= S_DONE;
                end
                S_RD_SRCH: begin
                    if (r_scan == (AW+1)'(SLOTS)) begin
                        r_out <= '{slot_index: 8'd0, status: ST_NOTFOUND};
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_CMP_SRCH;
                    end
                end
                S_CMP_SRCH: begin
                    if (r_oc_q && r_ky_q == i_key_masked(r_in.key_value)) begin
                        r_out <= '{slot_index: 8'(r_scan), status: ST_OK};
                        r_state <= S_DONE;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                        r_state <= S_RD_SRCH;
                    end
                end
                S_DONE: begin
                    r_out_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // checks
    a_full_no_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK && r_in.func != FN_DELETE) |-> r_new != '0)
        else $error("allocation without a free slot");
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready)
        else $error("input accepted while busy");
    a_ins_pos_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK && is_ins) |-> r_pos != '0)
        else $error("insert at sentinel");
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_free == '0) |-> r_cnt == AW'(SLOTS-1))
        else $error("free chain empty with slots left");
endmodule
`default_nettype wire
